### sv/huffman_code_packer_macros.svh
// assertion macros for the huffman code packer
// expects i_clk and i_rst_n in the scope of each use
`ifndef HUFFMAN_CODE_PACKER_MACROS_SVH
`define HUFFMAN_CODE_PACKER_MACROS_SVH
`ifndef SYNTHESIS
`define HCP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("hcp check failed");
`define HCP_ASSERT_NR(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("hcp reset check failed");
`else
`define HCP_ASSERT(lbl, prop)
`define HCP_ASSERT_NR(lbl, prop)
`endif
`endif

### sv/hcp_pkg.sv
// shared types and constants of the huffman code packer
// no dependencies
package hcp_pkg;

    localparam int OP_W    = 2;
    localparam int SYM_W   = 8;
    localparam int LEN_W   = 6;
    localparam int CODE_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 3;
    localparam int ACC_W   = CODE_W + BYTE_W;
    localparam int TOT_W   = 6;

    localparam int DEF_MAX_CODE_LEN = 32;
    localparam int DEF_NUM_SYMBOLS  = 256;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        OUT_BYTE,
        OUT_ERR,
        OUT_PART,
        OUT_TRL
    } t_out_sel;

    typedef struct packed {
        logic     tbl_write;
        logic     tbl_read;
        logic     acc_load;
        logic     acc_shift;
        logic     pend_commit;
        logic     pend_clear;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic total_ge8;
        logic total_ge16;
        logic pend_nonzero;
        logic out_free;
    } t_dp_status;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } t_entry;

endpackage

### sv/huffman_code_packer.sv
// huffman code packer top level: controller plus datapath
// depends on hcp_pkg, hcp_ctrl, hcp_datapath and huffman_code_packer_macros.svh
// input channel i_valid/o_stall carries op, symbol, code_len and code_bits;
// result channel o_valid/i_stall carries one packed byte, trailer or error
// per transfer, with o_last on the final result of an input item
// a load writes the code table at once
// an encode gives 0 to 4 output bytes: a table read, then the accumulator
// is built from the read code and the pending bits, then the bytes are shifted
// out of it one at a time; a symbol with no code gives an error result instead
// a flush gives an optional partial byte, then a trailer
// the first byte reaches o_valid through the table read, the accumulator and
// the output register, an error result through the table read and the output register
// one item is worked on at a time; the output register holds one byte
// reset clears the valid bits, the pending bits and the output valid bit;
// table contents are kept until overwritten
// when the receiver stalls, the output register holds and the sequencer
// waits; o_stall drops once the item's last result is in the output register
module huffman_code_packer #(
    parameter int MAX_CODE_LEN = hcp_pkg::DEF_MAX_CODE_LEN,
    parameter int NUM_SYMBOLS  = hcp_pkg::DEF_NUM_SYMBOLS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [hcp_pkg::OP_W-1:0]      i_op,
    input  logic [hcp_pkg::SYM_W-1:0]     i_symbol,
    input  logic [hcp_pkg::LEN_W-1:0]     i_code_len,
    input  logic [hcp_pkg::CODE_W-1:0]    i_code_bits,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [hcp_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_is_trailer,
    output logic [hcp_pkg::CNT_W-1:0]     o_unused_bits,
    output logic                          o_no_code_error,
    output logic                          o_last
);
    import hcp_pkg::*;

`include "huffman_code_packer_macros.svh"

    t_dp_cmd    cmd;
    t_dp_status status;

    hcp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_op     (i_op),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    hcp_datapath #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .NUM_SYMBOLS  (NUM_SYMBOLS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_symbol        (i_symbol),
        .i_code_len      (i_code_len),
        .i_code_bits     (i_code_bits),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_is_trailer    (o_is_trailer),
        .o_unused_bits   (o_unused_bits),
        .o_no_code_error (o_no_code_error),
        .o_last          (o_last)
    );

    `HCP_ASSERT_NR(a_rst_clears_out, !i_rst_n |=> !o_valid)
    `HCP_ASSERT(a_trailer_form, o_valid && o_is_trailer |-> o_last && !o_no_code_error && (o_out_byte == '0))
    `HCP_ASSERT(a_error_form, o_valid && o_no_code_error |-> o_last && !o_is_trailer && (o_unused_bits == '0))
    `HCP_ASSERT(a_encode_busy, i_valid && !o_stall && (i_op == OP_ENCODE) |=> o_stall)

endmodule

### sv/hcp_ctrl.sv
// controller of the huffman code packer: sequences load, encode and flush
// depends on hcp_pkg
module hcp_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [hcp_pkg::OP_W-1:0]    i_op,
    output logic                        o_stall,
    input  hcp_pkg::t_dp_status         i_status,
    output hcp_pkg::t_dp_cmd            o_cmd
);
    import hcp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_EMIT,
        S_FLUSH,
        S_FLUSH_TRL
    } t_state;

    t_state  r_state, n_state;
    logic    r_stall;
    t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (t_op'(i_op))
                        OP_LOAD: begin
                            cmd.tbl_write = 1'b1;
                        end
                        OP_ENCODE: begin
                            cmd.tbl_read = 1'b1;
                            n_state      = S_LOOKUP;
                        end
                        OP_FLUSH: begin
                            n_state = S_FLUSH;
                        end
                        OP_NONE: begin
                            n_state = S_IDLE;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LOOKUP: begin
                if (!i_status.hit) begin
                    if (i_status.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OUT_ERR;
                        cmd.out_last = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    cmd.acc_load = 1'b1;
                    n_state      = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.total_ge8) begin
                    if (i_status.out_free) begin
                        cmd.out_load  = 1'b1;
                        cmd.out_sel   = OUT_BYTE;
                        cmd.out_last  = !i_status.total_ge16;
                        cmd.acc_shift = 1'b1;
                        if (!i_status.total_ge16) begin
                            cmd.pend_commit = 1'b1;
                            n_state         = S_IDLE;
                        end
                    end
                end else begin
                    cmd.pend_commit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    if (i_status.pend_nonzero) begin
                        cmd.out_sel = OUT_PART;
                        n_state     = S_FLUSH_TRL;
                    end else begin
                        cmd.out_sel    = OUT_TRL;
                        cmd.out_last   = 1'b1;
                        cmd.pend_clear = 1'b1;
                        n_state        = S_IDLE;
                    end
                end
            end
            S_FLUSH_TRL: begin
                if (i_status.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = OUT_TRL;
                    cmd.out_last   = 1'b1;
                    cmd.pend_clear = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= (n_state != S_IDLE);
        end
    end

    assign o_stall = r_stall;
    assign o_cmd   = cmd;

endmodule

### sv/hcp_datapath.sv
// datapath of the huffman code packer: code table, valid bits,
// bit accumulator, pending byte and output register; depends on hcp_pkg
module hcp_datapath #(
    parameter int MAX_CODE_LEN = hcp_pkg::DEF_MAX_CODE_LEN,
    parameter int NUM_SYMBOLS  = hcp_pkg::DEF_NUM_SYMBOLS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [hcp_pkg::SYM_W-1:0]     i_symbol,
    input  logic [hcp_pkg::LEN_W-1:0]     i_code_len,
    input  logic [hcp_pkg::CODE_W-1:0]    i_code_bits,
    input  hcp_pkg::t_dp_cmd              i_cmd,
    output hcp_pkg::t_dp_status           o_status,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [hcp_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_is_trailer,
    output logic [hcp_pkg::CNT_W-1:0]     o_unused_bits,
    output logic                          o_no_code_error,
    output logic                          o_last
);
    import hcp_pkg::*;

    localparam int LEN_CAP = (MAX_CODE_LEN > CODE_W) ? CODE_W : MAX_CODE_LEN;
    localparam int IDX_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

    t_entry                  r_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0]  r_valid;
    t_entry                  r_rd;
    logic                    r_hit;

    logic [ACC_W-1:0]        r_acc;
    logic [TOT_W-1:0]        r_total;
    logic [BYTE_W-1:0]       r_pend_byte;
    logic [CNT_W-1:0]        r_pend_cnt;

    logic                    r_out_valid;
    logic [BYTE_W-1:0]       r_out_byte;
    logic                    r_out_trl;
    logic [CNT_W-1:0]        r_out_unused;
    logic                    r_out_err;
    logic                    r_out_last;

    logic                    in_range;
    logic [IDX_W-1:0]        idx;
    t_entry                  wr_entry;
    logic [CODE_W:0]         len_mask;
    logic [CODE_W-1:0]       masked;
    logic [ACC_W-1:0]        acc_sh;
    logic [TOT_W-1:0]        tot_sh;

    assign in_range = {1'b0, i_symbol} < (SYM_W+1)'(NUM_SYMBOLS);
    assign idx      = i_symbol[IDX_W-1:0];

    always_comb begin
        wr_entry.bits = i_code_bits;
        wr_entry.len  = (i_code_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : i_code_len;
    end

    // code table
    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_write && in_range) begin
            r_mem[idx] <= wr_entry;
        end
        if (i_cmd.tbl_read && in_range) begin
            r_rd <= r_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit   <= 1'b0;
        end else begin
            if (i_cmd.tbl_write && in_range) begin
                r_valid[idx] <= 1'b1;
            end
            if (i_cmd.tbl_read) begin
                r_hit <= in_range && r_valid[idx];
            end
        end
    end

    // accumulator
    assign len_mask = ((CODE_W+1)'(1) << r_rd.len) - (CODE_W+1)'(1);
    assign masked   = r_rd.bits & len_mask[CODE_W-1:0];
    assign acc_sh   = r_acc >> BYTE_W;
    assign tot_sh   = r_total - TOT_W'(BYTE_W);

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_load) begin
            r_acc   <= ACC_W'(r_pend_byte) | (ACC_W'(masked) << r_pend_cnt);
            r_total <= TOT_W'(r_pend_cnt) + r_rd.len;
        end else if (i_cmd.acc_shift) begin
            r_acc   <= acc_sh;
            r_total <= tot_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_byte <= '0;
            r_pend_cnt  <= '0;
        end else if (i_cmd.pend_clear) begin
            r_pend_byte <= '0;
            r_pend_cnt  <= '0;
        end else if (i_cmd.pend_commit) begin
            if (i_cmd.acc_shift) begin
                r_pend_byte <= acc_sh[BYTE_W-1:0];
                r_pend_cnt  <= tot_sh[CNT_W-1:0];
            end else begin
                r_pend_byte <= r_acc[BYTE_W-1:0];
                r_pend_cnt  <= r_total[CNT_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_byte   <= '0;
            r_out_trl    <= 1'b0;
            r_out_unused <= '0;
            r_out_err    <= 1'b0;
            r_out_last   <= i_cmd.out_last;
            unique case (i_cmd.out_sel)
                OUT_BYTE: r_out_byte   <= r_acc[BYTE_W-1:0];
                OUT_ERR:  r_out_err    <= 1'b1;
                OUT_PART: r_out_byte   <= r_pend_byte;
                OUT_TRL: begin
                    r_out_trl    <= 1'b1;
                    r_out_unused <= CNT_W'(0) - r_pend_cnt;
                end
                default:  r_out_err    <= 1'b0;
            endcase
        end
    end

    always_comb begin
        o_status.hit          = r_hit;
        o_status.total_ge8    = r_total >= TOT_W'(BYTE_W);
        o_status.total_ge16   = r_total >= TOT_W'(2 * BYTE_W);
        o_status.pend_nonzero = r_pend_cnt != '0;
        o_status.out_free     = !r_out_valid || !i_stall;
    end

    assign o_valid         = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_is_trailer    = r_out_trl;
    assign o_unused_bits   = r_out_unused;
    assign o_no_code_error = r_out_err;
    assign o_last          = r_out_last;

endmodule

### dv/testbench.sv
// self-checking testbench for huffman_code_packer: code table loads, encodes and flushes
// drives the input channel from a queue of items and predicts every packed byte, trailer and error
// depends on hcp_pkg and the huffman_code_packer rtl
module testbench;
    import hcp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 430;

    typedef struct packed {
        t_op                op;
        logic [SYM_W-1:0]   sym;
        logic [LEN_W-1:0]   len;
        logic [CODE_W-1:0]  code;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic               trailer;
        logic [CNT_W-1:0]   unused;
        logic               err;
        logic               fin;
    } t_packed_out;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic [OP_W-1:0]        i_op = OP_NONE;
    logic [SYM_W-1:0]       i_symbol = '0;
    logic [LEN_W-1:0]       i_code_len = '0;
    logic [CODE_W-1:0]      i_code_bits = '0;
    logic                   i_stall = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic [BYTE_W-1:0]      o_out_byte;
    logic                   o_is_trailer;
    logic [CNT_W-1:0]       o_unused_bits;
    logic                   o_no_code_error;
    logic                   o_last;

    t_item                  pending_items[$];
    t_packed_out            expected_bytes[$];

    // predicted packer state
    logic [LEN_W-1:0]       tbl_len[256];
    logic [CODE_W-1:0]      tbl_code[256];
    bit                     tbl_ok[256];
    logic [BYTE_W-1:0]      acc_bits = '0;
    int                     acc_cnt = 0;

    int                     taken_items = 0;
    int                     total_items = 1;
    int                     send_idle_pct = 20;
    int                     recv_stall_pct = 76;
    int                     mismatches = 0;
    int                     cycles = 0;

    huffman_code_packer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_symbol        (i_symbol),
        .i_code_len      (i_code_len),
        .i_code_bits     (i_code_bits),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_is_trailer    (o_is_trailer),
        .o_unused_bits   (o_unused_bits),
        .o_no_code_error (o_no_code_error),
        .o_last          (o_last)
    );

    always #1 i_clk = ~i_clk;

    task automatic add_item(input t_op op, input int sym, input int len, input logic [31:0] code);
        t_item it;
        it.op = op;
        it.sym = SYM_W'(sym);
        it.len = LEN_W'(len);
        it.code = code;
        pending_items.push_back(it);
    endtask

    task automatic pack_item(input t_item it);
        logic [ACC_W-1:0] mask;
        logic [ACC_W-1:0] acc;
        int               cut;
        int               total;
        t_packed_out      r;
        case (it.op)
            OP_LOAD: begin
                tbl_len[it.sym] = (it.len > LEN_W'(32)) ? LEN_W'(32) : it.len;
                tbl_code[it.sym] = it.code;
                tbl_ok[it.sym] = 1'b1;
            end
            OP_ENCODE: begin
                if (!tbl_ok[it.sym]) begin
                    r = '{8'd0, 1'b0, 3'd0, 1'b1, 1'b1};
                    expected_bytes.push_back(r);
                end else begin
                    cut = int'(tbl_len[it.sym]);
                    mask = (cut >= 32) ? {8'd0, 32'hFFFF_FFFF} : ((40'd1 << cut) - 40'd1);
                    acc = {32'd0, acc_bits} | (({8'd0, tbl_code[it.sym]} & mask) << acc_cnt);
                    total = acc_cnt + cut;
                    while (total >= 8) begin
                        r = '{acc[7:0], 1'b0, 3'd0, 1'b0, total < 16};
                        expected_bytes.push_back(r);
                        acc = acc >> 8;
                        total = total - 8;
                    end
                    acc_bits = acc[7:0];
                    acc_cnt = total;
                end
            end
            OP_FLUSH: begin
                if (acc_cnt != 0) begin
                    r = '{acc_bits, 1'b0, 3'd0, 1'b0, 1'b0};
                    expected_bytes.push_back(r);
                end
                r = '{8'd0, 1'b1, (acc_cnt != 0) ? 3'(8 - acc_cnt) : 3'd0, 1'b0, 1'b1};
                expected_bytes.push_back(r);
                acc_bits = '0;
                acc_cnt = 0;
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                pack_item(pending_items[0]);
                void'(pending_items.pop_front());
                taken_items++;
                if (taken_items >= 2 * total_items / 3) begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end else if (taken_items >= total_items / 3) begin
                    send_idle_pct = 76;
                    recv_stall_pct = 20;
                end
            end
            if (!(i_valid && o_stall)) begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_op <= pending_items[0].op;
                    i_symbol <= pending_items[0].sym;
                    i_code_len <= pending_items[0].len;
                    i_code_bits <= pending_items[0].code;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected transfer expected none actual byte %0d trailer %0d",
                             $time, o_out_byte, o_is_trailer);
                end else begin
                    check_field("out_byte", expected_bytes[0].data, o_out_byte);
                    check_field("is_trailer", expected_bytes[0].trailer, o_is_trailer);
                    check_field("unused_bits", expected_bytes[0].unused, o_unused_bits);
                    check_field("no_code_error", expected_bytes[0].err, o_no_code_error);
                    check_field("last", expected_bytes[0].fin, o_last);
                    void'(expected_bytes.pop_front());
                end
            end
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        int sel;
        int sym;
        int len;
        int coded_syms[$];

        // directed part
        add_item(OP_FLUSH, 0, 0, 32'h0);
        add_item(OP_ENCODE, 0, 63, 32'hFFFF_FFFF);
        add_item(OP_LOAD, 0, 0, 32'hFFFF_FFFF);
        add_item(OP_ENCODE, 0, 0, 32'h0);
        add_item(OP_LOAD, 255, 32, 32'hFFFF_FFFF);
        add_item(OP_ENCODE, 255, 0, 32'h0);
        add_item(OP_LOAD, 1, 63, 32'hA5A5_5A5A);
        add_item(OP_ENCODE, 1, 0, 32'h0);
        add_item(OP_LOAD, 2, 3, 32'hFFFF_FFF5);
        add_item(OP_ENCODE, 2, 0, 32'h0);
        add_item(OP_ENCODE, 2, 0, 32'h0);
        add_item(OP_ENCODE, 255, 0, 32'h0);
        add_item(OP_NONE, 170, 42, 32'h5555_AAAA);
        add_item(OP_FLUSH, 0, 0, 32'h0);
        add_item(OP_LOAD, 3, 8, 32'h0000_0000);
        add_item(OP_ENCODE, 3, 0, 32'h0);
        add_item(OP_ENCODE, 3, 0, 32'h0);
        add_item(OP_FLUSH, 255, 63, 32'hFFFF_FFFF);
        add_item(OP_LOAD, 4, 1, 32'h0000_0001);
        add_item(OP_ENCODE, 4, 0, 32'h0);
        add_item(OP_FLUSH, 0, 0, 32'h0);
        add_item(OP_ENCODE, 128, 0, 32'h0);
        add_item(OP_NONE, 0, 0, 32'h0);

        // random part: a code set first, then mostly encodes of loaded symbols
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            sel = (i < 16) ? 0 : $urandom_range(0, 99);
            sym = $urandom_range(0, 255);
            if (sel < 14) begin
                sel = $urandom_range(0, 19);
                if (sel == 0) begin
                    len = 0;
                end else if (sel < 14) begin
                    len = $urandom_range(1, 10);
                end else if (sel < 18) begin
                    len = $urandom_range(11, 32);
                end else begin
                    len = $urandom_range(33, 63);
                end
                coded_syms.push_back(sym);
                add_item(OP_LOAD, sym, len, $urandom);
            end else if (sel < 82) begin
                if (coded_syms.size() > 0 && $urandom_range(0, 9) != 0) begin
                    sym = coded_syms[$urandom_range(0, coded_syms.size() - 1)];
                end
                add_item(OP_ENCODE, sym, $urandom_range(0, 63), $urandom);
            end else if (sel < 94) begin
                add_item(OP_FLUSH, sym, $urandom_range(0, 63), $urandom);
            end else begin
                add_item(OP_NONE, sym, $urandom_range(0, 63), $urandom);
            end
        end
        add_item(OP_FLUSH, 0, 0, 32'h0);
        total_items = pending_items.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

### sim.f
+incdir+sv
sv/hcp_pkg.sv
sv/hcp_ctrl.sv
sv/hcp_datapath.sv
sv/huffman_code_packer.sv
dv/testbench.sv
